FILE: rtl/mpes_pkg.sv
`default_nettype none

package mpes_pkg;

  localparam int unsigned PHASES       = 4;
  localparam int unsigned CHANNELS     = 16;
  localparam int unsigned PAUSE_TICKS  = 100000;
  localparam int unsigned BEHIND_TICKS = 10000;
  localparam int unsigned ITER_LIMIT   = 838;

  localparam int unsigned TIME_W   = 64;
  localparam int unsigned PERIOD_W = 32;
  localparam int unsigned FRAC_W   = 17;
  localparam int unsigned ITER_W   = 10;
  localparam int unsigned LEVEL_W  = 16;
  localparam int unsigned NPHASE_W = 3;
  localparam int unsigned PH_W     = 2;

  localparam logic [FRAC_W-1:0] Q16_ONE = FRAC_W'(65536);

  // phase count upper clamp
  localparam int unsigned PHASE_CAP = (PHASES < 4) ? PHASES : 4;

  // channels at or above CHANNELS read as low
  localparam logic [LEVEL_W-1:0] CH_MASK =
    LEVEL_W'((64'd1 << CHANNELS) - 64'd1);

  typedef enum logic [1:0] {
    MODE_NORMAL = 2'd0,
    MODE_LOW    = 2'd1,
    MODE_HIGH   = 2'd2,
    MODE_STOP   = 2'd3
  } run_mode_t;

  typedef enum logic [2:0] {
    REG_PERIOD  = 3'd0,
    REG_MODE    = 3'd1,
    REG_PHASES  = 3'd2,
    REG_PATTERN = 3'd3,
    REG_FRAC0   = 3'd4,
    REG_FRAC1   = 3'd5,
    REG_FRAC2   = 3'd6,
    REG_FRAC3   = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic [TIME_W-1:0] now_time;
  } in_item_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] pin_levels;
    logic               levels_valid;
    logic [TIME_W-1:0]  next_switch_time;
    logic               is_stopped;
    logic               cycle_started;
  } out_item_t;

  typedef struct packed {
    cfg_reg_t    index;
    logic [63:0] wdata;
  } cfg_wr_t;

  // controller -> datapath
  typedef struct packed {
    logic capture;
    logic div_start;
    logic rebase;
    logic mul;
    logic add;
    logic fin;
    logic load_out;
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic stopped;
    logic paused;
    logic ph0;
    logic div_done;
  } dp_stat_t;

endpackage

`default_nettype wire

FILE: rtl/mpes_if.sv
`default_nettype none

interface mpes_in_if;
  import mpes_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface mpes_out_if;
  import mpes_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface mpes_cfg_if;
  import mpes_pkg::*;
  logic    valid;
  logic    ready;
  cfg_wr_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: rtl/mpes_div.sv
`default_nettype none

// Restoring divider, 0xFFFFFFFF / divisor, one quotient bit per cycle.
module mpes_div (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  input  wire logic [mpes_pkg::PERIOD_W-1:0] divisor,
  output logic      [mpes_pkg::PERIOD_W-1:0] quotient,
  output logic                               done
);
  import mpes_pkg::*;

  localparam int unsigned CNT_W = $clog2(PERIOD_W);

  logic                busy_r;
  logic                done_r;
  logic [CNT_W-1:0]    cnt_r;
  logic [PERIOD_W-1:0] rem_r;
  logic [PERIOD_W-1:0] quo_r;
  logic [PERIOD_W-1:0] dvs_r;

  logic [PERIOD_W:0]   shifted;
  logic                geq;
  logic [PERIOD_W:0]   diff;
  logic [PERIOD_W-1:0] rem_nxt;

  // dividend is all ones, so every shifted-in bit is 1
  assign shifted = {rem_r, 1'b1};
  assign geq     = shifted >= {1'b0, dvs_r};
  assign diff    = shifted - {1'b0, dvs_r};
  assign rem_nxt = geq ? diff[PERIOD_W-1:0] : shifted[PERIOD_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        rem_r  <= '0;
        quo_r  <= '0;
        dvs_r  <= divisor;
      end else if (busy_r) begin
        rem_r <= rem_nxt;
        quo_r <= {quo_r[PERIOD_W-2:0], geq};
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(PERIOD_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign quotient = quo_r;
  assign done     = done_r;

endmodule

`default_nettype wire

FILE: rtl/mpes_dp.sv
`default_nettype none

module mpes_dp (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire mpes_pkg::cfg_wr_t    cfg_wr,
  input  wire mpes_pkg::in_item_t   in_item,
  input  wire mpes_pkg::ctrl_cmd_t  cmd,
  output mpes_pkg::dp_stat_t        stat,
  output mpes_pkg::out_item_t       out_item
);
  import mpes_pkg::*;

  localparam int unsigned MULA_W = ITER_W + 17;
  localparam int unsigned PROD_W = MULA_W + PERIOD_W;

  // configuration
  logic [PERIOD_W-1:0] period_r;
  run_mode_t           mode_r;
  logic [NPHASE_W-1:0] nphase_r;
  logic [63:0]         pattern_r;
  logic [FRAC_W-1:0]   frac_r [4];

  // scheduler state
  logic [PH_W-1:0]     phase_r;
  logic [ITER_W-1:0]   iter_r;
  logic [TIME_W-1:0]   base_r;
  logic [PERIOD_W:0]   latched_r;
  logic                force_r;

  // per-transaction working registers
  logic [TIME_W-1:0]   now_r;
  logic [PERIOD_W-1:0] off_r;
  logic [TIME_W-1:0]   next_r;
  logic [PH_W-1:0]     cb_r;
  logic                started_r;
  out_item_t           out_r;

  logic                normal;
  logic [PH_W-1:0]     ph_eff;
  logic [NPHASE_W-1:0] n_eff;
  logic [PERIOD_W-1:0] quo;
  logic                div_done;
  logic [PERIOD_W-1:0] q_m2;
  logic [PERIOD_W-1:0] lim_cap;
  logic [PERIOD_W-1:0] limit;
  logic                do_rebase;
  logic [FRAC_W-1:0]   frac_sel;
  logic [MULA_W-1:0]   mul_a;
  logic [PROD_W-1:0]   prod;
  logic [PH_W-1:0]     cb_sel;
  logic                behind;
  logic                wrap;
  out_item_t           res;

  function automatic logic [LEVEL_W-1:0] levels_of(input logic [63:0] pat,
                                                   input logic [PH_W-1:0] ph);
    levels_of = pat[{ph, 4'b0000} +: LEVEL_W] & CH_MASK;
  endfunction

  assign normal = (mode_r == MODE_NORMAL);
  assign ph_eff = normal ? phase_r : '0;

  always_comb begin
    if (nphase_r == '0) begin
      n_eff = NPHASE_W'(1);
    end else if (nphase_r > NPHASE_W'(PHASE_CAP)) begin
      n_eff = NPHASE_W'(PHASE_CAP);
    end else begin
      n_eff = nphase_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r  <= '0;
      mode_r    <= MODE_STOP;
      nphase_r  <= NPHASE_W'(2);
      pattern_r <= '0;
      frac_r[0] <= '0;
      frac_r[1] <= Q16_ONE;
      frac_r[2] <= Q16_ONE;
      frac_r[3] <= Q16_ONE;
    end else if (cfg_we) begin
      unique case (cfg_wr.index)
        REG_PERIOD:  period_r  <= cfg_wr.wdata[PERIOD_W-1:0];
        REG_MODE:    mode_r    <= run_mode_t'(cfg_wr.wdata[1:0]);
        REG_PHASES:  nphase_r  <= cfg_wr.wdata[NPHASE_W-1:0];
        REG_PATTERN: pattern_r <= cfg_wr.wdata;
        REG_FRAC0:   frac_r[0] <= cfg_wr.wdata[FRAC_W-1:0];
        REG_FRAC1:   frac_r[1] <= cfg_wr.wdata[FRAC_W-1:0];
        REG_FRAC2:   frac_r[2] <= cfg_wr.wdata[FRAC_W-1:0];
        REG_FRAC3:   frac_r[3] <= cfg_wr.wdata[FRAC_W-1:0];
        default:     ;
      endcase
    end
  end

  mpes_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .divisor  (period_r),
    .quotient (quo),
    .done     (div_done)
  );

  // iteration limit: min(q - 2, ITER_LIMIT), zero raised to one
  assign q_m2    = quo - PERIOD_W'(2);
  assign lim_cap = (q_m2 > PERIOD_W'(ITER_LIMIT)) ? PERIOD_W'(ITER_LIMIT) : q_m2;
  assign limit   = (lim_cap == '0) ? PERIOD_W'(1) : lim_cap;
  assign do_rebase = force_r || (latched_r != {1'b0, period_r}) ||
                     ({{(PERIOD_W-ITER_W){1'b0}}, iter_r} == limit);

  assign frac_sel = normal ? frac_r[phase_r] : Q16_ONE;
  assign mul_a    = {1'b0, iter_r, 16'h0000} + MULA_W'(frac_sel);
  assign prod     = PROD_W'(mul_a) * PROD_W'(period_r);

  always_comb begin
    if (normal) begin
      cb_sel = (ph_eff == '0) ? PH_W'(n_eff - 1'b1) : ph_eff - 1'b1;
    end else begin
      cb_sel = (mode_r == MODE_LOW) ? PH_W'(0) : PH_W'(1);
    end
  end

  assign behind = (now_r >= TIME_W'(BEHIND_TICKS)) &&
                  (next_r < now_r - TIME_W'(BEHIND_TICKS));
  assign wrap   = behind || !normal ||
                  ({1'b0, ph_eff} + NPHASE_W'(1) >= n_eff);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= '0;
      iter_r    <= '0;
      base_r    <= '0;
      latched_r <= '1;
      force_r   <= 1'b0;
    end else begin
      if (cmd.rebase && do_rebase) begin
        base_r    <= now_r;
        iter_r    <= '0;
        latched_r <= {1'b0, period_r};
        force_r   <= 1'b0;
      end
      if (cmd.fin) begin
        if (wrap) begin
          phase_r <= '0;
          iter_r  <= iter_r + 1'b1;
          if (behind) begin
            force_r <= 1'b1;
          end
        end else begin
          phase_r <= phase_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      now_r     <= in_item.now_time;
      started_r <= 1'b0;
    end
    if (cmd.rebase) begin
      started_r <= 1'b1;
    end
    if (cmd.mul) begin
      off_r <= prod[16 +: PERIOD_W];
      cb_r  <= cb_sel;
    end
    if (cmd.add) begin
      next_r <= base_r + TIME_W'(off_r);
    end
    if (cmd.load_out) begin
      out_r <= res;
    end
  end

  always_comb begin
    res = '0;
    if (mode_r == MODE_STOP) begin
      res.is_stopped = 1'b1;
    end else if (period_r == '0) begin
      res.pin_levels       = levels_of(pattern_r, PH_W'(0));
      res.levels_valid     = 1'b1;
      res.next_switch_time = now_r + TIME_W'(PAUSE_TICKS);
    end else begin
      res.pin_levels       = levels_of(pattern_r, cb_r);
      res.levels_valid     = 1'b1;
      res.next_switch_time = next_r;
      res.cycle_started    = started_r;
    end
  end

  assign stat.stopped  = (mode_r == MODE_STOP);
  assign stat.paused   = (period_r == '0);
  assign stat.ph0      = (ph_eff == '0);
  assign stat.div_done = div_done;
  assign out_item      = out_r;

endmodule

`default_nettype wire

FILE: rtl/mpes_ctrl.sv
`default_nettype none

module mpes_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  output logic                     out_valid,
  input  wire logic                out_ready,
  input  wire mpes_pkg::dp_stat_t  stat,
  output mpes_pkg::ctrl_cmd_t      cmd
);
  import mpes_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_REB,
    S_MUL,
    S_ADD,
    S_FIN,
    S_OUT
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;
  logic   out_valid_nxt;
  logic   out_free;

  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          if (stat.stopped || stat.paused) begin
            state_nxt = S_OUT;
          end else if (stat.ph0) begin
            cmd.div_start = 1'b1;
            state_nxt     = S_DIV;
          end else begin
            state_nxt = S_MUL;
          end
        end
      end
      S_DIV: begin
        if (stat.div_done) begin
          state_nxt = S_REB;
        end
      end
      S_REB: begin
        cmd.rebase = 1'b1;
        state_nxt  = S_MUL;
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_ADD;
      end
      S_ADD: begin
        cmd.add   = 1'b1;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        cmd.fin   = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

FILE: rtl/multiphase_pwm_edge_scheduler.sv
// Flow: a stopped or paused firing goes from accept straight to output; a firing in
//   the middle of a period runs multiply, add and update; a firing that opens a period
//   first runs the 32-step iteration-limit divider (one quotient bit per cycle).
// Throughput: one transaction at a time; the next firing is taken while the previous result
//   waits in the output register.
// Reset (rst_n, synchronous): registers take their documented values, the generator is
//   stopped, phase and iteration return to zero and the next period start rebases.
`default_nettype none

module multiphase_pwm_edge_scheduler (
  input  wire logic clk,
  input  wire logic rst_n,
  mpes_in_if.sink   in_ch,
  mpes_out_if.source out_ch,
  mpes_cfg_if.sink  cfg_ch
);
  import mpes_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;
  logic      in_ready;
  logic      out_valid;
  out_item_t out_item;
  logic      cfg_we;

  // Always ready; user must write config only while no firing is in flight (unchecked).
  assign cfg_ch.ready = 1'b1;
  assign cfg_we       = cfg_ch.valid;

  // Sequencer: accept, optional divide + rebase check at period start, then offset multiply,
  // base add, far-behind check, state update and output; stopped or paused skip to output.
  mpes_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Registers, scheduler state, divider, multiplier and output register.
  mpes_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wr   (cfg_ch.data),
    .in_item  (in_ch.data),
    .cmd      (cmd),
    .stat     (stat),
    .out_item (out_item)
  );

  assign in_ch.ready  = in_ready;
  assign out_ch.valid = out_valid;
  assign out_ch.data  = out_item;

`ifndef ASSERT_OFF
  // A taken firing keeps the input closed on the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("input accepted twice in a row");

  // The divider is only started by an accepted firing.
  a_div_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |-> (in_ch.valid && in_ch.ready))
    else $error("divider started without a firing");

  // The output register is never overwritten while a result waits.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_ch.valid || out_ch.ready))
    else $error("pending result overwritten");

  // A stopped report carries no levels and no schedule.
  a_stopped_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.data.is_stopped) |->
      (!out_ch.data.levels_valid && !out_ch.data.cycle_started &&
       out_ch.data.next_switch_time == '0 && out_ch.data.pin_levels == '0))
    else $error("stopped result carries data");
`endif

endmodule

`default_nettype wire
